/* hw/rtl/sca_pkg.sv */
// ----------------------------------------------------------------------------
// Size class allocator package
// Shared codes, field widths and the result item type of the allocator.
// ----------------------------------------------------------------------------
package sca_pkg;

    localparam int CLS_W     = 5;
    localparam int PAGE_W    = 20;
    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 32;
    localparam int HDR_BYTES = 4;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_START = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_HEAP   = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_HEAD_WAIT,
        S_LINK_WAIT,
        S_CARVE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] user_address;
        logic [CLS_W-1:0]  size_class;
        status_t           status;
    } result_t;

endpackage

/* hw/rtl/sca_head_ram.sv */
// ----------------------------------------------------------------------------
// Free list head memory
// One entry per size class, synchronous read, with a valid flag per entry
// that reset and a heap restart clear at once.
// ----------------------------------------------------------------------------
module sca_head_ram #(
    parameter int ENTRIES = 16,
    parameter int AW      = 4,
    parameter int DW      = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          clr,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    output logic          rd_valid,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          wr_valid
);

    logic [DW-1:0] head_mem [ENTRIES];
    logic          valid_reg [ENTRIES];
    logic [DW-1:0] rd_data_reg;
    logic          rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            head_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= head_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            for (int i = 0; i < ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (we) begin
            valid_reg[wr_addr] <= wr_valid;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

/* hw/rtl/sca_link_ram.sv */
// ----------------------------------------------------------------------------
// Free list link memory
// One next-block link per heap block, one write and one registered read
// per cycle.
// ----------------------------------------------------------------------------
module sca_link_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 17
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] link_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= link_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/sca_ctrl.sv */
// ----------------------------------------------------------------------------
// Allocator sequencer
// Decodes one item, walks the head and link memories, carves fresh pages
// and holds the heap window registers and the bump pointer.
// ----------------------------------------------------------------------------
module sca_ctrl #(
    parameter int PAGE_BYTES      = 4096,
    parameter int NUM_CLASSES     = 16,
    parameter int HEAP_BLOCKS     = 65536,
    parameter int MIN_BLOCK_BYTES = 64,
    parameter int IDX_W           = 16,
    parameter int CLS_IDX_W       = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic                           item_op,
    input  logic [sca_pkg::SIZE_W-1:0]     item_size,
    input  logic [sca_pkg::ADDR_W-1:0]     item_addr,
    input  logic [sca_pkg::CLS_W-1:0]      item_cls,
    input  logic                           cfg_we,
    input  logic [sca_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [sca_pkg::PAGE_W-1:0]     cfg_wdata,
    output logic                           head_clr,
    output logic                           head_rd_en,
    output logic [CLS_IDX_W-1:0]           head_rd_addr,
    input  logic [IDX_W-1:0]               head_rd_data,
    input  logic                           head_rd_valid,
    output logic                           head_we,
    output logic [CLS_IDX_W-1:0]           head_wr_addr,
    output logic [IDX_W-1:0]               head_wr_data,
    output logic                           head_wr_valid,
    output logic                           link_rd_en,
    output logic [IDX_W-1:0]               link_rd_addr,
    input  logic [IDX_W:0]                 link_rd_data,
    output logic                           link_we,
    output logic [IDX_W-1:0]               link_wr_addr,
    output logic [IDX_W:0]                 link_wr_data,
    output logic                           res_valid,
    input  logic                           res_ready,
    output sca_pkg::result_t               res
);

    localparam int LOG_PAGE = $clog2(PAGE_BYTES);
    localparam int LOG_MIN  = $clog2(MIN_BLOCK_BYTES);
    localparam int PG_SH    = LOG_PAGE - LOG_MIN;
    localparam int CNT_W    = (PG_SH > 0) ? PG_SH : 1;
    localparam int EXT_A    = sca_pkg::PAGE_W + LOG_PAGE;
    localparam int EXT_B    = IDX_W + LOG_MIN;
    localparam int EXT_AB   = (EXT_A > EXT_B) ? EXT_A : EXT_B;
    localparam int EXT_W    = ((EXT_AB > sca_pkg::ADDR_W) ? EXT_AB : sca_pkg::ADDR_W) + 1;
    localparam longint WIN_PAGES =
        (longint'(HEAP_BLOCKS) * longint'(MIN_BLOCK_BYTES)) / longint'(PAGE_BYTES);
    localparam int PAGE_BLKS = PAGE_BYTES / MIN_BLOCK_BYTES;
    localparam int PW = sca_pkg::PAGE_W;
    localparam int CW = sca_pkg::CLS_W;
    localparam int AW = sca_pkg::ADDR_W;

    sca_pkg::state_t           state_reg, state_next;
    logic                      op_reg, op_next;
    logic [AW:0]               size3_reg, size3_next;
    logic [AW-1:0]             addr_reg, addr_next;
    logic [CW-1:0]             rcls_reg, rcls_next;
    logic [CW-1:0]             cls_reg, cls_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [PW-1:0]             start_reg, start_next;
    logic [PW-1:0]             limit_reg, limit_next;
    logic [PW-1:0]             bump_reg, bump_next;
    logic [IDX_W-1:0]          cur_reg, cur_next;
    logic [IDX_W-1:0]          prev_reg, prev_next;
    logic                      prev_v_reg, prev_v_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    sca_pkg::result_t          res_reg, res_next;

    logic [NUM_CLASSES-1:0]    fit;
    logic [CW-1:0]             alloc_cls;
    logic                      rel_bad;
    logic [AW-1:0]             blk32;
    logic [EXT_W-1:0]          base_ext;
    logic [EXT_W-1:0]          off_ext;
    logic [EXT_W-1:0]          off_blk;
    logic [5:0]                sum;
    logic                      small_cls;
    logic [5:0]                sh;
    logic [PW:0]               pages;
    logic [PW:0]               end_page;
    logic [AW-1:0]             window_end;
    logic                      no_room;
    logic [PW-1:0]             pg_off;
    logic [EXT_W-1:0]          first_ext;
    logic [IDX_W-1:0]          first;
    logic [IDX_W-1:0]          stride;
    logic [IDX_W-1:0]          last;
    logic [CNT_W:0]            cnt_full;
    logic [EXT_W-1:0]          fresh_addr;
    logic [EXT_W-1:0]          pop_addr;

    always_comb begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
            fit[k] = ((size3_reg >> (LOG_MIN + k)) == '0);
        end
        alloc_cls = '0;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if (fit[k]) begin
                alloc_cls = CW'(k);
            end
        end
    end

    assign blk32    = addr_reg - AW'(sca_pkg::HDR_BYTES);
    assign base_ext = EXT_W'(start_reg) << LOG_PAGE;
    assign off_ext  = EXT_W'(blk32) - base_ext;
    assign off_blk  = off_ext >> LOG_MIN;
    assign rel_bad  = (addr_reg[LOG_PAGE-1:0] == '0)
                   || (rcls_reg >= CW'(NUM_CLASSES))
                   || (EXT_W'(blk32) < base_ext)
                   || (off_ext[LOG_MIN-1:0] != '0)
                   || (off_blk >= EXT_W'(HEAP_BLOCKS));

    assign sum        = 6'(LOG_MIN) + {1'b0, cls_reg};
    assign small_cls  = (sum < 6'(LOG_PAGE));
    assign sh         = sum - 6'(LOG_PAGE);
    assign pages      = small_cls ? (PW+1)'(1) : ((PW+1)'(1) << sh);
    assign end_page   = {1'b0, bump_reg} + pages;
    assign window_end = AW'(start_reg) + AW'(WIN_PAGES);
    assign no_room    = (!small_cls && (sh > 6'(PW)))
                     || (end_page > {1'b0, limit_reg})
                     || (AW'(end_page) > window_end);
    assign pg_off     = bump_reg - start_reg;
    assign first_ext  = EXT_W'(pg_off) << PG_SH;
    assign first      = first_ext[IDX_W-1:0];
    assign stride     = IDX_W'(1) << cls_reg;
    assign last       = first + IDX_W'(PAGE_BLKS) - stride;
    assign cnt_full   = ((CNT_W+1)'(1) << (6'(LOG_PAGE) - sum)) - (CNT_W+1)'(1);
    assign fresh_addr = (EXT_W'(bump_reg) << LOG_PAGE) + EXT_W'(sca_pkg::HDR_BYTES);
    assign pop_addr   = base_ext + (EXT_W'(idx_reg) << LOG_MIN)
                      + EXT_W'(sca_pkg::HDR_BYTES);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        size3_next   = size3_reg;
        addr_next    = addr_reg;
        rcls_next    = rcls_reg;
        cls_next     = cls_reg;
        idx_next     = idx_reg;
        start_next   = start_reg;
        limit_next   = limit_reg;
        bump_next    = bump_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        prev_v_next  = prev_v_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        item_ready   = 1'b0;
        res_valid    = 1'b0;
        head_clr     = 1'b0;
        head_rd_en   = 1'b0;
        head_rd_addr = '0;
        head_we      = 1'b0;
        head_wr_addr = cls_reg[CLS_IDX_W-1:0];
        head_wr_data = '0;
        head_wr_valid = 1'b0;
        link_rd_en   = 1'b0;
        link_rd_addr = head_rd_data;
        link_we      = 1'b0;
        link_wr_addr = '0;
        link_wr_data = '0;

        case (state_reg)
            sca_pkg::S_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    op_next    = item_op;
                    size3_next = {1'b0, item_size} + (AW+1)'(sca_pkg::HDR_BYTES - 1);
                    addr_next  = item_addr;
                    rcls_next  = item_cls;
                    state_next = sca_pkg::S_DECODE;
                end
            end
            sca_pkg::S_DECODE: begin
                if (op_reg == sca_pkg::OP_ALLOC) begin
                    cls_next = alloc_cls;
                    if (fit == '0) begin
                        res_next.user_address = '0;
                        res_next.size_class   = '0;
                        res_next.status       = sca_pkg::ST_TOO_LARGE;
                        state_next            = sca_pkg::S_RESULT;
                    end else begin
                        head_rd_en   = 1'b1;
                        head_rd_addr = alloc_cls[CLS_IDX_W-1:0];
                        state_next   = sca_pkg::S_HEAD_WAIT;
                    end
                end else begin
                    cls_next = rcls_reg;
                    idx_next = off_blk[IDX_W-1:0];
                    res_next.user_address = '0;
                    res_next.size_class   = rcls_reg;
                    if (rel_bad) begin
                        res_next.status = sca_pkg::ST_IGNORED;
                        state_next      = sca_pkg::S_RESULT;
                    end else begin
                        head_rd_en   = 1'b1;
                        head_rd_addr = rcls_reg[CLS_IDX_W-1:0];
                        state_next   = sca_pkg::S_HEAD_WAIT;
                    end
                end
            end
            sca_pkg::S_HEAD_WAIT: begin
                res_next.size_class = cls_reg;
                if (op_reg == sca_pkg::OP_RELEASE) begin
                    link_we       = 1'b1;
                    link_wr_addr  = idx_reg;
                    link_wr_data  = {head_rd_valid, head_rd_data};
                    head_we       = 1'b1;
                    head_wr_data  = idx_reg;
                    head_wr_valid = 1'b1;
                    res_next.status = sca_pkg::ST_OK;
                    state_next    = sca_pkg::S_RESULT;
                end else if (head_rd_valid) begin
                    link_rd_en = 1'b1;
                    idx_next   = head_rd_data;
                    state_next = sca_pkg::S_LINK_WAIT;
                end else if (no_room) begin
                    res_next.user_address = '0;
                    res_next.status       = sca_pkg::ST_NO_HEAP;
                    state_next            = sca_pkg::S_RESULT;
                end else begin
                    bump_next             = end_page[PW-1:0];
                    res_next.user_address = fresh_addr[AW-1:0];
                    res_next.status       = sca_pkg::ST_OK;
                    if (small_cls) begin
                        head_we       = 1'b1;
                        head_wr_data  = last;
                        head_wr_valid = 1'b1;
                        cur_next      = first + stride;
                        prev_next     = first;
                        prev_v_next   = 1'b0;
                        cnt_next      = cnt_full[CNT_W-1:0];
                        state_next    = sca_pkg::S_CARVE;
                    end else begin
                        state_next = sca_pkg::S_RESULT;
                    end
                end
            end
            sca_pkg::S_LINK_WAIT: begin
                head_we               = 1'b1;
                head_wr_data          = link_rd_data[IDX_W-1:0];
                head_wr_valid         = link_rd_data[IDX_W];
                res_next.user_address = pop_addr[AW-1:0];
                res_next.status       = sca_pkg::ST_OK;
                state_next            = sca_pkg::S_RESULT;
            end
            sca_pkg::S_CARVE: begin
                link_we      = 1'b1;
                link_wr_addr = cur_reg;
                link_wr_data = {prev_v_reg, prev_reg};
                prev_next    = cur_reg;
                prev_v_next  = 1'b1;
                cur_next     = cur_reg + stride;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = sca_pkg::S_RESULT;
                end
            end
            sca_pkg::S_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = sca_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sca_pkg::S_IDLE;
            end
        endcase

        if (cfg_we) begin
            case (cfg_addr)
                sca_pkg::CFG_HEAP_START: begin
                    start_next = cfg_wdata;
                    bump_next  = cfg_wdata;
                    head_clr   = 1'b1;
                end
                sca_pkg::CFG_HEAP_LIMIT: begin
                    limit_next = cfg_wdata;
                end
                default: begin
                    limit_next = limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sca_pkg::S_IDLE;
            start_reg <= '0;
            limit_reg <= PW'(1024);
            bump_reg  <= '0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
            limit_reg <= limit_next;
            bump_reg  <= bump_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        size3_reg  <= size3_next;
        addr_reg   <= addr_next;
        rcls_reg   <= rcls_next;
        cls_reg    <= cls_next;
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        prev_v_reg <= prev_v_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
    end

    assign res = res_reg;

endmodule

/* hw/rtl/size_class_free_list_allocator_top.sv */
// ----------------------------------------------------------------------------
// Size class free list allocator
// Hands out and takes back heap blocks of power-of-two size classes.
// ----------------------------------------------------------------------------
// The slave channel takes one request item: tuser selects allocate or
// release, tdata carries the size, the released address and its class.
// The master channel returns one result item per request: the user address
// and class in tdata, the status in tuser.
// The window registers are written through cfg_we, cfg_addr and cfg_wdata;
// writing the heap start reloads the bump pointer and empties all lists.
// Requests are worked one at a time through the head and link memories.
// A pushed release, an allocation out of heap or one served by fresh pages
// go through decode, head wait and result, a list pop adds link wait, and a
// request too large or an ignored release goes from decode to result. An
// allocation that carves a page of class size cs adds a carve state: one link
// write per block pushed, PAGE_BYTES/cs - 1 (63 at most with default sizes).
// The result lands in an output register, so a new request is taken while
// the receiver stalls; a second result then waits until the first is taken.
// Reset empties all free lists and restores the default window at once.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_top #(
    parameter int PAGE_BYTES      = 4096,
    parameter int NUM_CLASSES     = 16,
    parameter int HEAP_BLOCKS     = 65536,
    parameter int MIN_BLOCK_BYTES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // request_size, release_address, release_class, zero fill
    input  logic [71:0]                   s_tdata,
    // operation
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // user_address, size_class, zero fill
    output logic [39:0]                   m_tdata,
    // status
    output logic [1:0]                    m_tuser,
    input  logic                          cfg_we,
    input  logic [sca_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [sca_pkg::PAGE_W-1:0]    cfg_wdata
);

    localparam int IDX_W     = $clog2(HEAP_BLOCKS);
    localparam int CLS_IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    logic                   head_clr;
    logic                   head_rd_en;
    logic [CLS_IDX_W-1:0]   head_rd_addr;
    logic [IDX_W-1:0]       head_rd_data;
    logic                   head_rd_valid;
    logic                   head_we;
    logic [CLS_IDX_W-1:0]   head_wr_addr;
    logic [IDX_W-1:0]       head_wr_data;
    logic                   head_wr_valid;
    logic                   link_rd_en;
    logic [IDX_W-1:0]       link_rd_addr;
    logic [IDX_W:0]         link_rd_data;
    logic                   link_we;
    logic [IDX_W-1:0]       link_wr_addr;
    logic [IDX_W:0]         link_wr_data;
    logic                   res_valid;
    logic                   res_ready;
    sca_pkg::result_t       res;
    logic                   m_valid_reg;
    sca_pkg::result_t       out_reg;

    sca_head_ram #(
        .ENTRIES (NUM_CLASSES),
        .AW      (CLS_IDX_W),
        .DW      (IDX_W)
    ) u_head (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clr      (head_clr),
        .rd_en    (head_rd_en),
        .rd_addr  (head_rd_addr),
        .rd_data  (head_rd_data),
        .rd_valid (head_rd_valid),
        .we       (head_we),
        .wr_addr  (head_wr_addr),
        .wr_data  (head_wr_data),
        .wr_valid (head_wr_valid)
    );

    sca_link_ram #(
        .DEPTH (HEAP_BLOCKS),
        .AW    (IDX_W),
        .DW    (IDX_W + 1)
    ) u_link (
        .aclk    (aclk),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data),
        .we      (link_we),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data)
    );

    sca_ctrl #(
        .PAGE_BYTES      (PAGE_BYTES),
        .NUM_CLASSES     (NUM_CLASSES),
        .HEAP_BLOCKS     (HEAP_BLOCKS),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .IDX_W           (IDX_W),
        .CLS_IDX_W       (CLS_IDX_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (s_tvalid),
        .item_ready    (s_tready),
        .item_op       (s_tuser[0]),
        .item_size     (s_tdata[31:0]),
        .item_addr     (s_tdata[63:32]),
        .item_cls      (s_tdata[68:64]),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .head_clr      (head_clr),
        .head_rd_en    (head_rd_en),
        .head_rd_addr  (head_rd_addr),
        .head_rd_data  (head_rd_data),
        .head_rd_valid (head_rd_valid),
        .head_we       (head_we),
        .head_wr_addr  (head_wr_addr),
        .head_wr_data  (head_wr_data),
        .head_wr_valid (head_wr_valid),
        .link_rd_en    (link_rd_en),
        .link_rd_addr  (link_rd_addr),
        .link_rd_data  (link_rd_data),
        .link_we       (link_we),
        .link_wr_addr  (link_wr_addr),
        .link_wr_data  (link_wr_data),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_reg.size_class, out_reg.user_address};
    assign m_tuser  = out_reg.status;

`ifndef SYNTH
    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> (m_tvalid && m_tuser == $past(res.status)))
        else $error("result not moved into the output register");

    a_too_large_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == sca_pkg::ST_TOO_LARGE) |-> (m_tdata[36:0] == '0))
        else $error("oversized request returned an address or class");

    a_fail_no_address: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == sca_pkg::ST_NO_HEAP || m_tuser == sca_pkg::ST_IGNORED))
        |-> (m_tdata[31:0] == '0))
        else $error("failed request returned a nonzero address");
`endif

endmodule

/* bench/tb_size_class_free_list_allocator_top.sv */
// ----------------------------------------------------------------------------
// Size class free list allocator testbench
// Streams allocate and release requests into the allocator and checks every
// result item against a cycle-free model of the class lists and bump pointer.
// The window registers are moved between phases, and random gaps, stalls and
// one long receiver hold-off stress both channels.
// ----------------------------------------------------------------------------
module tb_size_class_free_list_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_BYTES      = 4096;
    localparam int NUM_CLASSES     = 16;
    localparam int HEAP_BLOCKS     = 65536;
    localparam int MIN_BLOCK_BYTES = 64;
    localparam int CARVE_PAD       = 100;
    localparam int CHOKE_CYCLES    = 300;

    typedef struct {
        sca_pkg::op_t                op;
        logic [sca_pkg::SIZE_W-1:0]  size;
        logic [sca_pkg::ADDR_W-1:0]  addr;
        logic [sca_pkg::CLS_W-1:0]   cls;
    } request_t;

    typedef struct {
        sca_pkg::op_t                op;
        logic [sca_pkg::ADDR_W-1:0]  addr;
        logic [sca_pkg::CLS_W-1:0]   cls;
        sca_pkg::status_t            st;
    } outcome_t;

    typedef struct {
        logic [sca_pkg::ADDR_W-1:0]  addr;
        logic [sca_pkg::CLS_W-1:0]   cls;
    } block_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [71:0]                   s_tdata   = '0;
    logic [0:0]                    s_tuser   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [39:0]                   m_tdata;
    logic [1:0]                    m_tuser;
    logic                          cfg_we    = 1'b0;
    logic [sca_pkg::CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [sca_pkg::PAGE_W-1:0]    cfg_wdata = '0;

    size_class_free_list_allocator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

    // Heap state as the allocator should hold it.
    logic [sca_pkg::PAGE_W-1:0] base_page  = '0;
    logic [sca_pkg::PAGE_W-1:0] limit_page = 20'd1024;
    logic [sca_pkg::PAGE_W-1:0] bump_page  = '0;
    bit                         head_ok [NUM_CLASSES];
    bit [15:0]                  head_ix [NUM_CLASSES];
    bit                         link_ok [HEAP_BLOCKS];
    bit [15:0]                  link_ix [HEAP_BLOCKS];

    request_t pending[$];
    outcome_t awaited[$];
    block_t   live[$];
    request_t in_flight;
    int       handed    = 0;
    int       taken     = 0;
    int       errors    = 0;
    int       gap_left  = 0;
    int       stall_left = 0;
    int       choke_left = 0;
    bit       choke_req = 1'b0;
    bit       quiet     = 1'b0;

    function automatic void push_free(int cls, logic [15:0] ix);
        link_ok[ix]  = head_ok[cls];
        link_ix[ix]  = head_ix[cls];
        head_ok[cls] = 1'b1;
        head_ix[cls] = ix;
    endfunction

    function automatic outcome_t allocate(logic [sca_pkg::SIZE_W-1:0] size);
        outcome_t          o;
        longint unsigned   need, cs, wbase, pages, end_pg, blk, first, off;
        int                cls;
        logic [15:0]       ix;
        o.op   = sca_pkg::OP_ALLOC;
        o.addr = '0;
        o.cls  = '0;
        o.st   = sca_pkg::ST_OK;
        need   = 64'(size) + sca_pkg::HDR_BYTES;
        cls    = 0;
        cs     = MIN_BLOCK_BYTES;
        while (cls < NUM_CLASSES && need > cs) begin
            cls++;
            cs = cs << 1;
        end
        if (cls >= NUM_CLASSES) begin
            o.st = sca_pkg::ST_TOO_LARGE;
            return o;
        end
        o.cls = sca_pkg::CLS_W'(cls);
        wbase = 64'(base_page) * PAGE_BYTES;
        if (head_ok[cls]) begin
            ix           = head_ix[cls];
            head_ok[cls] = link_ok[ix];
            head_ix[cls] = link_ix[ix];
            o.addr = sca_pkg::ADDR_W'(wbase + 64'(ix) * MIN_BLOCK_BYTES
                                      + sca_pkg::HDR_BYTES);
            return o;
        end
        pages  = (cs < PAGE_BYTES) ? 1 : cs / PAGE_BYTES;
        end_pg = 64'(bump_page) + pages;
        if (end_pg > 64'(limit_page) ||
            end_pg > 64'(base_page) + 64'(HEAP_BLOCKS) * MIN_BLOCK_BYTES / PAGE_BYTES) begin
            o.st = sca_pkg::ST_NO_HEAP;
            return o;
        end
        blk = 64'(bump_page) * PAGE_BYTES;
        if (cs < PAGE_BYTES) begin
            first = (blk - wbase) / MIN_BLOCK_BYTES;
            for (off = cs; off + cs <= PAGE_BYTES; off += cs) begin
                push_free(cls, 16'(first + off / MIN_BLOCK_BYTES));
            end
        end
        bump_page = sca_pkg::PAGE_W'(end_pg);
        o.addr    = sca_pkg::ADDR_W'(blk + sca_pkg::HDR_BYTES);
        return o;
    endfunction

    function automatic outcome_t release_block(logic [sca_pkg::ADDR_W-1:0] addr,
                                               logic [sca_pkg::CLS_W-1:0] cls);
        outcome_t                   o;
        logic [sca_pkg::ADDR_W-1:0] blk;
        longint unsigned            wbase, off;
        o.op   = sca_pkg::OP_RELEASE;
        o.addr = '0;
        o.cls  = cls;
        o.st   = sca_pkg::ST_IGNORED;
        if (addr % PAGE_BYTES == 0 || cls >= NUM_CLASSES) begin
            return o;
        end
        blk   = addr - sca_pkg::HDR_BYTES;
        wbase = 64'(base_page) * PAGE_BYTES;
        if (64'(blk) < wbase) begin
            return o;
        end
        off = 64'(blk) - wbase;
        if (off % MIN_BLOCK_BYTES != 0 || off / MIN_BLOCK_BYTES >= HEAP_BLOCKS) begin
            return o;
        end
        push_free(int'(cls), 16'(off / MIN_BLOCK_BYTES));
        o.st = sca_pkg::ST_OK;
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic request_t alloc_req(logic [sca_pkg::SIZE_W-1:0] size);
        request_t r;
        r.op   = sca_pkg::OP_ALLOC;
        r.size = size;
        r.addr = $urandom;
        r.cls  = sca_pkg::CLS_W'($urandom);
        return r;
    endfunction

    function automatic request_t free_req(logic [sca_pkg::ADDR_W-1:0] addr,
                                          logic [sca_pkg::CLS_W-1:0] cls);
        request_t r;
        r.op   = sca_pkg::OP_RELEASE;
        r.size = $urandom;
        r.addr = addr;
        r.cls  = cls;
        return r;
    endfunction

    function automatic request_t make_item(int max_k);
        request_t        r;
        int              pick, k, j;
        longint unsigned lo, hi;
        r    = alloc_req($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25 && live.size() > 0) begin
            j = $urandom_range(0, live.size() - 1);
            r = free_req(live[j].addr, live[j].cls);
            live.delete(j);
        end else if (pick < 35) begin
            r = free_req($urandom, sca_pkg::CLS_W'($urandom));
        end else if (pick < 45) begin
            lo = 64'(base_page) * PAGE_BYTES +
                 64'($urandom_range(0, HEAP_BLOCKS + 255)) * MIN_BLOCK_BYTES;
            lo = lo + (($urandom_range(0, 3) == 0) ?
                       $urandom_range(0, MIN_BLOCK_BYTES - 1) : sca_pkg::HDR_BYTES);
            r = free_req(sca_pkg::ADDR_W'(lo),
                         sca_pkg::CLS_W'($urandom_range(0, NUM_CLASSES + 1)));
        end else if (pick >= 50) begin
            if ($urandom_range(0, 3) == 0) begin
                k = $urandom_range(0, max_k);
            end else begin
                k = $urandom_range(0, (max_k < 3) ? max_k : 3);
            end
            hi = (64'(MIN_BLOCK_BYTES) << k) - sca_pkg::HDR_BYTES;
            lo = (k == 0) ? 0 :
                 (64'(MIN_BLOCK_BYTES) << (k - 1)) - sca_pkg::HDR_BYTES + 1;
            r.size = sca_pkg::SIZE_W'(lo + $urandom_range(0, int'(hi - lo)));
        end
        return r;
    endfunction

    // Sender: one item offered at a time, with random gaps between items.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (in_flight.op == sca_pkg::OP_ALLOC) begin
                    awaited.push_back(allocate(in_flight.size));
                end else begin
                    awaited.push_back(release_block(in_flight.addr, in_flight.cls));
                end
                taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() > 0) begin
                    in_flight = pending.pop_front();
                    s_tdata  <= {3'b000, in_flight.cls, in_flight.addr, in_flight.size};
                    s_tuser  <= in_flight.op;
                    s_tvalid <= 1'b1;
                    gap_left = quiet ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            choke_left = 0;
        end else if (choke_left > 0) begin
            choke_left--;
            m_tready <= 1'b0;
        end else if (choke_req) begin
            choke_req  = 1'b0;
            choke_left = CHOKE_CYCLES;
            m_tready <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
        end
    end

    task automatic report_mismatch(string what, logic [sca_pkg::ADDR_W-1:0] got,
                                   logic [sca_pkg::ADDR_W-1:0] want);
        $display("%0t: %s mismatch, got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        outcome_t e;
        block_t   b;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], '0);
            end else begin
                e = awaited.pop_front();
                if (m_tdata[31:0] !== e.addr) begin
                    report_mismatch("user_address", m_tdata[31:0], e.addr);
                end
                if (m_tdata[36:32] !== e.cls) begin
                    report_mismatch("size_class", 32'(m_tdata[36:32]), 32'(e.cls));
                end
                if (m_tuser !== e.st) begin
                    report_mismatch("status", 32'(m_tuser), 32'(e.st));
                end
                if (e.op == sca_pkg::OP_ALLOC && e.st == sca_pkg::ST_OK &&
                    m_tdata[31:0] === e.addr) begin
                    b.addr = e.addr;
                    b.cls  = e.cls;
                    live.push_back(b);
                end
            end
        end
    end

    task automatic queue_item(request_t r);
        pending.push_back(r);
        handed++;
    endtask

    task automatic feed(int n, int max_k);
        repeat (n) begin
            while (pending.size() >= 6) begin
                @(negedge aclk);
            end
            queue_item(make_item(max_k));
        end
    endtask

    task automatic settle();
        while (taken != handed || awaited.size() != 0) begin
            @(negedge aclk);
        end
        repeat (CARVE_PAD) @(negedge aclk);
    endtask

    task automatic write_reg(sca_pkg::cfg_idx_t idx,
                             logic [sca_pkg::PAGE_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == sca_pkg::CFG_HEAP_START) begin
            base_page = val;
            bump_page = val;
            foreach (head_ok[c]) head_ok[c] = 1'b0;
            live.delete();
        end else begin
            limit_page = val;
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(sca_pkg::CFG_HEAP_START, '0);
        write_reg(sca_pkg::CFG_HEAP_LIMIT, 20'd1024);

        // Class boundaries, oversize requests and the end of the heap.
        queue_item(alloc_req(32'd0));
        queue_item(alloc_req(32'd60));
        queue_item(alloc_req(32'd61));
        queue_item(alloc_req(32'd4092));
        queue_item(alloc_req(32'd4093));
        queue_item(alloc_req(32'd2097148));
        queue_item(alloc_req(32'd2097149));
        queue_item(alloc_req(32'hFFFF_FFFF));
        queue_item(alloc_req(32'd2097148));
        // A released block comes back first; malformed releases are ignored.
        queue_item(free_req(32'h0000_0004, 5'd0));
        queue_item(alloc_req(32'd1));
        queue_item(free_req(32'h0000_1000, 5'd0));
        queue_item(free_req(32'h0000_0044, 5'd16));
        queue_item(free_req(32'h0000_0044, 5'd31));
        queue_item(free_req(32'h0000_0002, 5'd0));
        queue_item(free_req(32'h0000_0046, 5'd0));
        queue_item(free_req(32'h0040_0004, 5'd0));
        queue_item(free_req(32'h003F_FFC4, 5'd2));
        queue_item(alloc_req(32'd200));
        queue_item(free_req(32'hFFFF_FFFF, 5'd15));
        queue_item(alloc_req(32'd0));

        feed(40, 7);
        @(negedge aclk);
        choke_req = 1'b1;
        feed(80, 7);
        settle();

        write_reg(sca_pkg::CFG_HEAP_LIMIT, '1);
        write_reg(sca_pkg::CFG_HEAP_START, '1);
        queue_item(free_req(32'hFFFF_F044, 5'd0));
        queue_item(alloc_req(32'd10));
        feed(40, 15);
        settle();

        write_reg(sca_pkg::CFG_HEAP_START, 20'd1048000);
        feed(60, 15);
        settle();

        write_reg(sca_pkg::CFG_HEAP_LIMIT, '0);
        write_reg(sca_pkg::CFG_HEAP_START, 20'd5);
        feed(30, 15);
        settle();

        write_reg(sca_pkg::CFG_HEAP_LIMIT, '1);
        write_reg(sca_pkg::CFG_HEAP_START, 20'd7);
        quiet = 1'b1;
        feed(60, 6);
        quiet = 1'b0;
        feed(110, 15);
        settle();

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/sca_pkg.sv
hw/rtl/sca_head_ram.sv
hw/rtl/sca_link_ram.sv
hw/rtl/sca_ctrl.sv
hw/rtl/size_class_free_list_allocator_top.sv
bench/tb_size_class_free_list_allocator_top.sv
